// ===== hw/rtl/ectmr_pkg.sv =====
package ectmr_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 8;
    localparam int IRQ_W          = 8;
    localparam int SLOT_W         = 4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [ADDR_W-1:0] ADDR_STATUS = 8'h00;
    localparam logic [ADDR_W-1:0] ADDR_REV    = 8'h04;

    localparam logic [3:0] OFF_CTRL = 4'h0;
    localparam logic [3:0] OFF_BUF  = 4'h4;
    localparam logic [3:0] OFF_CNT  = 4'h8;

    localparam logic [DATA_W-1:0] REV_VALUE = 32'h0000_0000;

    // Bit positions inside a timer control word.
    localparam int CTL_START  = 0;
    localparam int CTL_UPDATE = 1;
    localparam int CTL_RELOAD = 2;
    localparam int CTL_IRQEN  = 3;
    localparam int CTL_EDGE   = 4;

    // Decoded form of one command beat.
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              tick;
        logic              err;
        logic              sel_status;
        logic              sel_ctrl;
        logic              sel_buf;
        logic              sel_cnt;
        logic [SLOT_W-1:0] slot;
    } acc_t;

    // What one timer reports on a tick.
    typedef struct packed {
        logic fire;
        logic edge_mode;
    } chan_evt_t;

endpackage

// ===== hw/rtl/ectmr_decode.sv =====
module ectmr_decode #(
    parameter int NUM_TIMERS = ectmr_pkg::NUM_TIMERS_DEF
) (
    input  logic [1:0]                     cmd,
    input  logic [ectmr_pkg::ADDR_W-1:0]   address,
    output ectmr_pkg::acc_t                acc
);
    import ectmr_pkg::*;

    logic [SLOT_W-1:0] slot;
    logic [3:0]        off;
    logic              is_acc;
    logic              timer_ok;

    assign slot     = address[ADDR_W-1:4];
    assign off      = address[3:0];
    assign is_acc   = (cmd == CMD_READ) || (cmd == CMD_WRITE);
    assign timer_ok = (slot != '0) && (slot <= SLOT_W'(NUM_TIMERS));

    always_comb
    begin
        acc            = '0;
        acc.rd         = (cmd == CMD_READ);
        acc.wr         = (cmd == CMD_WRITE);
        acc.tick       = (cmd == CMD_TICK);
        acc.slot       = slot;
        if (is_acc)
        begin
            if (address == ADDR_STATUS)
            begin
                acc.sel_status = 1'b1;
            end
            else if (address == ADDR_REV)
            begin
                acc.err = 1'b0;
            end
            else if (!timer_ok)
            begin
                acc.err = 1'b1;
            end
            else
            begin
                case (off)
                    OFF_CTRL: acc.sel_ctrl = 1'b1;
                    OFF_BUF:  acc.sel_buf  = 1'b1;
                    OFF_CNT:  acc.sel_cnt  = 1'b1;
                    default:  acc.err      = 1'b1;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/ectmr_chan.sv =====
module ectmr_chan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  ectmr_pkg::acc_t                acc,
    input  logic                           sel,
    input  logic [ectmr_pkg::DATA_W-1:0]   write_data,
    output logic [ectmr_pkg::DATA_W-1:0]   rd_data,
    output ectmr_pkg::chan_evt_t           evt
);
    import ectmr_pkg::*;

    logic [DATA_W-1:0] ctrl_reg,   ctrl_next;
    logic [DATA_W-1:0] buf_reg,    buf_next;
    logic [DATA_W-1:0] period_reg, period_next;
    logic [DATA_W-1:0] remain_reg, remain_next;

    logic tick;
    logic expire;
    logic wr_ctrl;
    logic wr_buf;

    assign tick    = accept && acc.tick && ctrl_reg[CTL_START];
    // A count of one or zero both expire on this tick.
    assign expire  = tick && (remain_reg[DATA_W-1:1] == '0);
    assign wr_ctrl = accept && acc.wr && sel && acc.sel_ctrl;
    assign wr_buf  = accept && acc.wr && sel && acc.sel_buf;

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        buf_next    = buf_reg;
        period_next = period_reg;
        remain_next = remain_reg;
        if (wr_ctrl)
        begin
            ctrl_next = write_data;
            if (write_data[CTL_UPDATE])
            begin
                period_next = buf_reg;
            end
            if (write_data[CTL_START])
            begin
                remain_next = write_data[CTL_UPDATE] ? buf_reg : period_reg;
            end
        end
        if (wr_buf)
        begin
            buf_next = write_data;
        end
        if (tick)
        begin
            if (!expire)
            begin
                remain_next = remain_reg - DATA_W'(1);
            end
            else if (ctrl_reg[CTL_RELOAD])
            begin
                remain_next = period_reg;
            end
            else
            begin
                ctrl_next[CTL_START] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            buf_reg    <= '0;
            period_reg <= '0;
            remain_reg <= '0;
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            buf_reg    <= buf_next;
            period_reg <= period_next;
            remain_reg <= remain_next;
        end
    end

    always_comb
    begin
        rd_data = '0;
        if (acc.rd && sel)
        begin
            if (acc.sel_ctrl)
            begin
                rd_data = ctrl_reg;
            end
            else if (acc.sel_buf)
            begin
                rd_data = buf_reg;
            end
            else if (acc.sel_cnt && ctrl_reg[CTL_START])
            begin
                rd_data = remain_reg;
            end
        end
    end

    assign evt.fire      = expire && ctrl_reg[CTL_IRQEN];
    assign evt.edge_mode = ctrl_reg[CTL_EDGE];

endmodule

// ===== hw/rtl/eight_channel_countdown_timer.sv =====
// A result beat appears in the cycle after its command beat is taken.
// Throughput: one command beat per cycle while results are taken; every timer updates in parallel.
// A result waiting in the output register does not block a new command
// as long as the consumer takes it in the same cycle.
// Reset clears all timer registers, status and level state to zero; the interrupt line outputs are not reset.
module eight_channel_countdown_timer #(
    parameter int NUM_TIMERS = ectmr_pkg::NUM_TIMERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  logic [1:0]                     cmd,
    input  logic [ectmr_pkg::ADDR_W-1:0]   address,
    input  logic [ectmr_pkg::DATA_W-1:0]   write_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [ectmr_pkg::DATA_W-1:0]   read_data,
    output logic [ectmr_pkg::IRQ_W-1:0]    irq_lines,
    output logic                           access_error
);
    import ectmr_pkg::*;

    logic                          accept;
    acc_t                          acc;
    logic [NUM_TIMERS-1:0][DATA_W-1:0] chan_rd;
    chan_evt_t [NUM_TIMERS-1:0]    chan_evt;

    logic [NUM_TIMERS-1:0] status_reg, status_next;
    logic [NUM_TIMERS-1:0] level_reg,  level_next;
    logic [NUM_TIMERS-1:0] pulses;

    logic                  rsp_valid_reg;
    logic [DATA_W-1:0]     read_data_reg, read_data_next;
    logic [IRQ_W-1:0]      irq_reg, irq_next;
    logic                  err_reg;

    logic [NUM_TIMERS+DATA_W-1:0] status_ext;
    logic [NUM_TIMERS+IRQ_W-1:0]  irq_ext;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    ectmr_decode #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_decode (
        .cmd     (cmd),
        .address (address),
        .acc     (acc)
    );

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_chan
        ectmr_chan u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .acc        (acc),
            .sel        (acc.slot == SLOT_W'(i + 1)),
            .write_data (write_data),
            .rd_data    (chan_rd[i]),
            .evt        (chan_evt[i])
        );
    end

    always_comb
    begin
        status_next = status_reg;
        level_next  = level_reg;
        pulses      = '0;
        if (accept && acc.wr && acc.sel_status)
        begin
            status_next = status_reg & ~write_data[NUM_TIMERS-1:0];
            level_next  = level_reg  & ~write_data[NUM_TIMERS-1:0];
        end
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (chan_evt[i].fire)
            begin
                status_next[i] = 1'b1;
                if (chan_evt[i].edge_mode)
                begin
                    pulses[i] = 1'b1;
                end
                else
                begin
                    level_next[i] = 1'b1;
                end
            end
        end
    end

    assign status_ext = {{DATA_W{1'b0}}, status_reg};
    assign irq_ext    = {{IRQ_W{1'b0}}, level_next | pulses};
    assign irq_next   = irq_ext[IRQ_W-1:0];

    always_comb
    begin
        read_data_next = '0;
        if (acc.rd && acc.sel_status)
        begin
            read_data_next = status_ext[DATA_W-1:0];
        end
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            read_data_next = read_data_next | chan_rd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= '0;
            level_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
            err_reg       <= acc.err;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = read_data_reg;
    assign irq_lines    = irq_reg;
    assign access_error = err_reg;

    // Every taken command beat yields a result beat in the next cycle.
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("command beat produced no result beat");

    // An unmapped access never returns data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && err_reg) |-> (read_data_reg == '0))
        else $error("access error with nonzero read data");

    // A level interrupt line is only high while its status bit is set.
    a_level_in_status: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg & ~status_reg) == '0)
        else $error("level interrupt without status bit");

    // Status bits rise only as the result of a timer tick.
    a_status_rise: assert property (@(posedge clk) disable iff (!rst_n)
        ((status_reg & ~$past(status_reg)) != '0)
            |-> $past(accept && (cmd == CMD_TICK)))
        else $error("status bit set without a tick");

endmodule
